/* design/wildcard_byte_signature_scanner_assert.svh */
// assertion macros for the wildcard byte signature scanner
// expects clk and arst_n in the scope of the module that includes it
`ifndef WILDCARD_BYTE_SIGNATURE_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_SIGNATURE_SCANNER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WBSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define WBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/wbss_pkg.sv */
// shared types and constants of the wildcard byte signature scanner
// no dependencies
package wbss_pkg;

	localparam int ADDR_W     = 64;
	localparam int MAX_PAT    = 16;
	localparam int LEN_W      = 5;
	localparam int MASK_W     = 16;
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;

	typedef logic [7:0]        byte_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;

	// register index, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_PAT_LOW  = 3'd0,
		REG_PAT_HIGH = 3'd1,
		REG_WC_MASK  = 3'd2,
		REG_PAT_LEN  = 3'd3,
		REG_FIND_ALL = 3'd4,
		REG_BASE     = 3'd5
	} reg_idx_t;

endpackage

/* design/wbss_byte_if.sv */
// input byte channel of the scanner: valid/ready plus byte and region end marker
// depends on wbss_pkg
interface wbss_byte_if;
	import wbss_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  region_last;

	modport source (output valid, output data_byte, output region_last, input ready);
	modport sink (input valid, input data_byte, input region_last, output ready);

endinterface

/* design/wbss_result_if.sv */
// result channel of the scanner: valid/ready plus found flag, address and last
// depends on wbss_pkg
interface wbss_result_if;
	import wbss_pkg::*;

	logic  valid;
	logic  ready;
	logic  found;
	addr_t match_address;
	logic  last;

	modport source (output valid, output found, output match_address, output last,
		input ready);
	modport sink (input valid, input found, input match_address, input last,
		output ready);

endinterface

/* design/wildcard_byte_signature_scanner.sv */
// wildcard byte signature scanner, top level
// depends on wbss_pkg, wbss_byte_if, wbss_result_if, wildcard_byte_signature_scanner_assert.svh
//
//  channel   dir   transfer                        payload
//  byte_in   in    valid & ready                   data_byte, region_last
//  result    out   valid & ready                   found, match_address, last
//  apb       in    psel & penable & pwrite         paddr, pwdata (reads on prdata)
//
// one byte per cycle while no stall backs up to the input; a byte is accepted into the
// window stage, compared there, and its result is registered in the output register
// as soon as that register is free (a stall can hold it in the compare stage).
// the output register lets a new byte in while a result waits; a stall only backs up
// when the compare stage holds a result too. a byte that gives no result never blocks
// the compare stage. reset clears all control state at once.
module wildcard_byte_signature_scanner
	import wbss_pkg::*;
#(
	parameter int PATTERN_BYTES = 16,
	parameter int OFFSET_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	wbss_byte_if.sink             byte_in,
	wbss_result_if.source         result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CAP   = (PATTERN_BYTES < MAX_PAT) ? PATTERN_BYTES : MAX_PAT;
	localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

	// configuration registers
	logic [63:0]       pat_low_q;
	logic [63:0]       pat_high_q;
	logic [MASK_W-1:0] wc_mask_q;
	len_t              pat_len_q;
	logic              find_all_q;
	addr_t             base_q;

	// scan state
	byte_t                  window_q [CAP];
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   first_found_q;

	// compare stage
	logic                   vld_s1;
	logic                   last_s1;
	logic                   check_s1;
	logic [OFFSET_BITS-1:0] start_s1;

	// output register
	logic  out_vld_q;
	logic  found_q;
	addr_t addr_q;
	logic  last_q;

	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	len_t        len_eff;
	logic [127:0] pat_bits;
	logic        hit_s1;
	logic        report_s1;
	logic        produce_s1;
	logic        out_free;
	logic        s1_go;
	logic        in_acc;
	logic        len_fits;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			wc_mask_q  <= '0;
			pat_len_q  <= len_t'(1);
			find_all_q <= 1'b0;
			base_q     <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PAT_LOW:  pat_low_q  <= pwdata;
				REG_PAT_HIGH: pat_high_q <= pwdata;
				REG_WC_MASK:  wc_mask_q  <= pwdata[MASK_W-1:0];
				REG_PAT_LEN:  pat_len_q  <= pwdata[LEN_W-1:0];
				REG_FIND_ALL: find_all_q <= pwdata[0];
				REG_BASE:     base_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PAT_LOW:  prdata = pat_low_q;
			REG_PAT_HIGH: prdata = pat_high_q;
			REG_WC_MASK:  prdata = {{(APB_DATA_W-MASK_W){1'b0}}, wc_mask_q};
			REG_PAT_LEN:  prdata = {{(APB_DATA_W-LEN_W){1'b0}}, pat_len_q};
			REG_FIND_ALL: prdata = {{(APB_DATA_W-1){1'b0}}, find_all_q};
			REG_BASE:     prdata = base_q;
			default:      prdata = '0;
		endcase
	end

	// length in use, capped at the window depth
	assign len_eff  = (pat_len_q > len_t'(CAP)) ? len_t'(CAP) : pat_len_q;
	assign pat_bits = {pat_high_q, pat_low_q};

	// ---------------- flow control ----------------
	assign out_free   = !out_vld_q || result.ready;
	assign produce_s1 = report_s1 || last_s1;
	assign s1_go      = vld_s1 && (!produce_s1 || out_free);
	assign byte_in.ready = !vld_s1 || s1_go;
	assign in_acc     = byte_in.valid && byte_in.ready;

	// ---------------- accept: window shift and offset ----------------
	assign len_fits = ({1'b0, offset_q} + {{OFFSET_BITS{1'b0}}, 1'b1})
		>= {{(OFFSET_BITS+1-LEN_W){1'b0}}, len_eff};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			window_q[0] <= byte_in.data_byte;
			for (int i = 1; i < CAP; i++) begin
				window_q[i] <= window_q[i-1];
			end
			last_s1  <= byte_in.region_last;
			check_s1 <= (len_eff != '0) && (offset_q != OFFSET_MAX) && len_fits;
			start_s1 <= offset_q + OFFSET_BITS'(1) - OFFSET_BITS'(len_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (in_acc) begin
				if (byte_in.region_last) begin
					offset_q <= '0;
				end else if (offset_q != OFFSET_MAX) begin
					offset_q <= offset_q + OFFSET_BITS'(1);
				end
				vld_s1 <= 1'b1;
			end else if (s1_go) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// ---------------- compare stage ----------------
	// window entry 0 is the newest byte, so pattern byte k sits at len-1-k
	always_comb begin
		logic [LEN_W-1:0] pos;
		hit_s1 = 1'b1;
		pos    = '0;
		for (int k = 0; k < CAP; k++) begin
			pos = len_eff - LEN_W'(k) - LEN_W'(1);
			if ((LEN_W'(k) < len_eff) && !wc_mask_q[k]
					&& (window_q[pos[IDX_W-1:0]] != pat_bits[8*k +: 8])) begin
				hit_s1 = 1'b0;
			end
		end
	end

	assign report_s1 = vld_s1 && check_s1 && hit_s1 && (find_all_q || !first_found_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_found_q <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				first_found_q <= 1'b0;
			end else if (report_s1) begin
				first_found_q <= 1'b1;
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go && produce_s1) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && produce_s1) begin
			found_q <= report_s1;
			last_q  <= last_s1;
			addr_q  <= report_s1
				? base_q + {{(ADDR_W-OFFSET_BITS){1'b0}}, start_s1}
				: '0;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.found         = found_q;
	assign result.match_address = addr_q;
	assign result.last          = last_q;

	// ---------------- assertions ----------------
`include "wildcard_byte_signature_scanner_assert.svh"

	`WBSS_ASSERT_NOW(a_plain_end, out_vld_q && !found_q, last_q && (addr_q == '0), "bad plain end")
	`WBSS_ASSERT_NOW(a_no_early_match, vld_s1 && !check_s1, !report_s1, "match before fit")
	`WBSS_ASSERT_NEXT(a_offset_clear, in_acc && byte_in.region_last, offset_q == '0, "offset kept")
	`WBSS_ASSERT_NEXT(a_first_mark, s1_go && report_s1 && !last_s1, first_found_q, "match not kept")
	`WBSS_ASSERT_NOW(a_backpressure, vld_s1 && produce_s1 && !out_free, !byte_in.ready, "byte taken")

endmodule

/* tb/wbss_scan_checker.sv */
// scoreboard of the wildcard byte signature scanner: mirrors the registers from apb
// writes, predicts the result of every accepted byte and checks the result channel
// depends on wbss_pkg, wbss_byte_if, wbss_result_if
module wbss_scan_checker
	import wbss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	wbss_byte_if                  byte_mon,
	wbss_result_if                res_mon,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    mismatches,
	output int                    pending
);

	typedef struct packed {
		logic  found;
		addr_t match_address;
		logic  last;
	} scan_hit_t;

	logic [63:0]       pat_low;
	logic [63:0]       pat_high;
	logic [MASK_W-1:0] wc_mask;
	len_t              pat_len;
	logic              find_all;
	addr_t             base;

	byte_t             window [MAX_PAT];
	logic [31:0]       offset;
	logic              hit_seen;
	scan_hit_t         hits_due [$];

	function automatic byte_t pat_byte(input int k);
		return (k < 8) ? pat_low[k*8 +: 8] : pat_high[(k-8)*8 +: 8];
	endfunction

	// window entry 0 is the newest byte, so pattern byte 0 sits at entry len-1
	function automatic logic window_hit(input int len);
		for (int k = 0; k < len; k++)
			if (!wc_mask[k] && window[len-1-k] != pat_byte(k))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic scan_byte(input byte_t data, input logic region_end);
		int          len;
		logic        report;
		logic [32:0] reach;
		addr_t       start;
		len = (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
		report = 1'b0;
		start = '0;
		for (int i = MAX_PAT-1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = data;
		reach = {1'b0, offset} + 33'd1;
		// a saturated offset never closes a match
		if (len > 0 && offset != '1 && reach >= len && window_hit(len)) begin
			start = addr_t'(reach - len);
			report = find_all || !hit_seen;
		end
		if (offset != '1)
			offset = offset + 32'd1;
		if (report)
			hit_seen = 1'b1;
		if (region_end) begin
			offset = '0;
			hit_seen = 1'b0;
		end
		if (report)
			hits_due.insert(hits_due.size(), scan_hit_t'{1'b1, base + start, region_end});
		else if (region_end)
			hits_due.insert(hits_due.size(), scan_hit_t'{1'b0, '0, 1'b1});
	endtask

	task automatic check_hit(input logic found, input addr_t match_address, input logic last);
		scan_hit_t due;
		if (hits_due.size() == 0) begin
			$error("unexpected result: found=%0b match_address=%h last=%0b",
				found, match_address, last);
			mismatches++;
			return;
		end
		due = hits_due.pop_front();
		if (found !== due.found) begin
			$error("found: expected %0b, actual %0b", due.found, found);
			mismatches++;
		end
		if (match_address !== due.match_address) begin
			$error("match_address: expected %h, actual %h", due.match_address, match_address);
			mismatches++;
		end
		if (last !== due.last) begin
			$error("last: expected %0b, actual %0b", due.last, last);
			mismatches++;
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
		case (reg_idx_t'(idx))
			REG_PAT_LOW:  pat_low = value;
			REG_PAT_HIGH: pat_high = value;
			REG_WC_MASK:  wc_mask = value[MASK_W-1:0];
			REG_PAT_LEN:  pat_len = value[LEN_W-1:0];
			REG_FIND_ALL: find_all = value[0];
			REG_BASE:     base = value;
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low = '0;
			pat_high = '0;
			wc_mask = '0;
			pat_len = len_t'(1);
			find_all = 1'b0;
			base = '0;
			foreach (window[i])
				window[i] = '0;
			offset = '0;
			hit_seen = 1'b0;
			hits_due.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			// results before bytes: a byte never produces a result at its own transfer
			if (res_mon.valid && res_mon.ready)
				check_hit(res_mon.found, res_mon.match_address, res_mon.last);
			if (byte_mon.valid && byte_mon.ready)
				scan_byte(byte_mon.data_byte, byte_mon.region_last);
			if (psel && penable && pwrite && pready)
				write_reg(paddr[5:3], pwdata);
			pending = hits_due.size();
		end
	end

endmodule

/* tb/wildcard_byte_signature_scanner_tb.sv */
// testbench top of the wildcard byte signature scanner: clock, reset, apb setup,
// byte stimulus with random gaps, result stalls and the final verdict
// depends on wbss_pkg, wbss_byte_if, wbss_result_if, wbss_scan_checker and the scanner
module wildcard_byte_signature_scanner_tb
	import wbss_pkg::*;
();

	localparam int COOLDOWN    = 6;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASES      = 8;
	localparam int PHASE_BYTES = 75;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    mismatches;
	int                    pending;
	int                    idle_cycles;

	logic                  hold_request;
	logic                  crowd;
	int                    send_run;
	logic                  send_eager;
	byte_t                 cur_pat [MAX_PAT];
	logic [MASK_W-1:0]     cur_mask;
	byte_t                 region_buf [$];

	wbss_byte_if   byte_ch ();
	wbss_result_if res_ch ();

	wildcard_byte_signature_scanner i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	wbss_scan_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_mon   (byte_ch),
		.res_mon    (res_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// setup, access, then idle before the next write
	task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// valid stays high between back-to-back bytes
	task automatic send_byte(input byte_t data, input logic region_end);
		int gap;
		if (send_run == 0) begin
			send_run = $urandom_range(4, 40);
			send_eager = $urandom_range(0, 1);
		end
		send_run--;
		gap = (send_eager || crowd) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= data;
		byte_ch.region_last <= region_end;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_region();
		foreach (region_buf[i])
			send_byte(region_buf[i], i == region_buf.size() - 1);
	endtask

	// stop offering bytes until every predicted result has been taken
	task automatic drain();
		byte_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (COOLDOWN) @(posedge clk);
	endtask

	// mostly pattern-like bytes, plus planted copies of the pattern
	task automatic build_region(input int eff);
		int n;
		int s;
		int copies;
		region_buf.delete();
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, eff + 10);
		for (int i = 0; i < n; i++) begin
			if (eff == 0 || $urandom_range(0, 2) == 0)
				region_buf.insert(region_buf.size(), byte_t'($urandom));
			else
				region_buf.insert(region_buf.size(), cur_pat[$urandom_range(0, eff - 1)]);
		end
		copies = (eff == 0 || n < eff || $urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
		repeat (copies) begin
			s = $urandom_range(0, n - eff);
			for (int k = 0; k < eff; k++)
				if (!cur_mask[k])
					region_buf[s+k] = cur_pat[k];
		end
	endtask

	task automatic random_phase(input int ph);
		int          len;
		int          eff;
		int          sent;
		logic [63:0] low;
		logic [63:0] high;
		logic [63:0] base;
		foreach (cur_pat[k])
			cur_pat[k] = byte_t'($urandom);
		cur_mask = ($urandom_range(0, 3) == 0) ? '0 : MASK_W'($urandom & $urandom);
		base = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0)
			len = $urandom_range(0, 31);
		else
			len = $urandom_range(1, 6);
		case (ph)
			0: begin
				len = 16;
				cur_mask = '0;
				base = '1;
				foreach (cur_pat[k])
					cur_pat[k] = 8'hFF;
			end
			1: begin
				len = 31;
				cur_mask = '1;
				base = '0;
			end
			2: len = 0;
			default: ;
		endcase
		for (int k = 0; k < 8; k++) begin
			low[k*8 +: 8] = cur_pat[k];
			high[k*8 +: 8] = cur_pat[k+8];
		end
		reg_write(REG_PAT_LOW, low);
		reg_write(REG_PAT_HIGH, high);
		reg_write(REG_WC_MASK, APB_DATA_W'(cur_mask));
		reg_write(REG_PAT_LEN, APB_DATA_W'(len));
		reg_write(REG_FIND_ALL, (ph == 1) ? 64'd1 : (ph == 0) ? 64'd0 : 64'($urandom_range(0, 1)));
		reg_write(REG_BASE, base);
		eff = (len > MAX_PAT) ? MAX_PAT : len;
		sent = 0;
		while (sent < PHASE_BYTES) begin
			build_region(eff);
			send_region();
			sent += region_buf.size();
		end
	endtask

	initial begin : stimulus
		hold_request = 1'b0;
		crowd = 1'b0;
		send_run = 0;
		send_eager = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.region_last <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one-byte pattern 00, first-match mode, then a lone plain end
		region_buf = '{8'h00, 8'hFF, 8'h00};
		send_region();
		region_buf = '{8'hFF};
		send_region();
		drain();

		// all mode, wildcard on byte 1, base near the top so addresses wrap
		reg_write(REG_PAT_LOW, 64'h0000_0000_DDCC_BBAA);
		reg_write(REG_WC_MASK, 64'h0002);
		reg_write(REG_PAT_LEN, 64'd4);
		reg_write(REG_FIND_ALL, 64'd1);
		reg_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
		region_buf = '{8'hAA, 8'h11, 8'hCC, 8'hDD, 8'hAA, 8'h00, 8'hCC, 8'hDD};
		send_region();
		// region shorter than the pattern
		region_buf = '{8'hAA, 8'h11, 8'hCC};
		send_region();
		drain();

		// empty pattern never matches
		reg_write(REG_PAT_LEN, 64'd0);
		region_buf = '{8'hAA, 8'hAA};
		send_region();
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 3) begin
				crowd = 1'b1;
				hold_request = 1'b1;
			end
			random_phase(ph);
			crowd = 1'b0;
			drain();
		end

		if (mismatches == 0)
			$display("[wildcard_byte_signature_scanner] OK");
		else
			$display("[wildcard_byte_signature_scanner] ERROR");
		$finish;
	end

	initial begin : result_sink
		int   hold;
		int   run;
		logic eager;
		run = 0;
		eager = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (run == 0) begin
				run = $urandom_range(4, 40);
				eager = $urandom_range(0, 1);
			end
			run--;
			if (hold_request) begin
				hold_request = 1'b0;
				hold = LONG_HOLD;
			end else begin
				hold = eager ? 0 : $urandom_range(0, 10);
			end
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
		end
	end

	// ends the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (byte_ch.valid && byte_ch.ready) ||
				(res_ch.valid && res_ch.ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[wildcard_byte_signature_scanner] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
